// ===== hw/rtl/vpa_pkg.sv =====
// Package for the variable partition allocator.
// Holds table sizes, segment entry type, status, policy and request codes.
// No dependencies.
package vpa_pkg;

    localparam int MAX_SEG = 64;
    localparam int IDX_W   = $clog2(MAX_SEG);
    localparam int CNT_W   = $clog2(MAX_SEG + 1);
    localparam int ADDR_W  = 16;
    localparam int ID_W    = 8;
    localparam int IN_W    = 32;
    localparam int OUT_W   = 72;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_SIZE  = 3'd1;
    localparam logic [2:0] ST_SHORT     = 3'd2;
    localparam logic [2:0] ST_NO_FIT    = 3'd3;
    localparam logic [2:0] ST_ID_MISS   = 3'd4;
    localparam logic [2:0] ST_FULL      = 3'd5;
    localparam logic [2:0] ST_BAD_POL   = 3'd6;

    localparam logic [1:0] POL_FIRST   = 2'd0;
    localparam logic [1:0] POL_BEST    = 2'd1;
    localparam logic [1:0] POL_WORST   = 2'd2;
    localparam logic [1:0] POL_INVALID = 2'd3;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [ADDR_W-1:0] length;
        logic [ID_W-1:0]   owner;
        logic              hole;
    } t_seg;

    localparam int SEG_W = $bits(t_seg);

endpackage

// ===== hw/rtl/vpa_seg_ram.sv =====
// Segment table memory: one write port, one read port, registered read data.
// Generic, no package dependency.
module vpa_seg_ram #(
    parameter int DATA_W = 41,
    parameter int DEPTH  = 64,
    parameter int AW     = 6
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [AW-1:0]     i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== hw/rtl/variable_partition_allocator.sv =====
// Variable partition allocator top level: request sequencer around the segment table.
// Depends on vpa_pkg and vpa_seg_ram.
//
//  channel      | dir | fields (low bit up)
//  s_axis_tdata | in  | process_id, request_size, fit_policy
//  s_axis_tuser | in  | req_type
//  m_axis_tdata | out | status, start_address, free_units, hole_total, owned_total, largest_hole
//  i_cfg        | in  | index 0 total_size, index 1 reserved_base
//
// A request scans the table, shifts it when a split or a merge moves entries, then scans it
// for the largest hole: the table scan, the shift and the largest-hole scan each go through
// the single read port one entry a cycle. A request failing the size or policy check returns
// from the check state; a missing hole, a full table or a missing id at the end of the scan.
// Reset and each config write rewrite entry zero in one cycle before a request is taken.
// The next request is taken while a result waits on m_axis.
module variable_partition_allocator (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic                             i_cfg_idx,
    input  logic [vpa_pkg::ADDR_W-1:0]       i_cfg_data,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [vpa_pkg::IN_W-1:0]         s_axis_tdata,  // process_id, request_size,
                                                            // fit_policy
    input  logic                             s_axis_tuser,  // req_type
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [vpa_pkg::OUT_W-1:0]        m_axis_tdata   // status, start_address,
                                                            // free_units, hole_total,
                                                            // owned_total, largest_hole
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_SHR   = 3'd3;
    localparam logic [2:0] S_SPL1  = 3'd4;
    localparam logic [2:0] S_SPL2  = 3'd5;
    localparam logic [2:0] S_SHL   = 3'd6;
    localparam logic [2:0] S_LSCAN = 3'd7;

    localparam int AW = vpa_pkg::ADDR_W;
    localparam int CW = vpa_pkg::CNT_W;
    localparam int XW = vpa_pkg::IDX_W;

    logic [2:0]    r_state;
    logic          r_done;
    logic          r_init;
    logic [AW-1:0] r_tot, r_base;
    logic [CW-1:0] r_cnt, r_holes, r_owned, r_idx, r_ridx, r_end;
    logic [1:0]    r_shd;
    logic          r_rvld;
    logic [AW-1:0] r_free, r_largest, r_addr, r_best;
    logic [2:0]    r_status;
    logic          r_type;
    logic [vpa_pkg::ID_W-1:0] r_pid;
    logic [AW-1:0] r_size;
    logic [1:0]    r_pol;
    logic          r_pick_vld, r_prev_vld, r_next_vld;
    logic [CW-1:0] r_pick;
    vpa_pkg::t_seg r_pick_ent, r_prev_ent, r_next_ent, r_last_ent;
    logic          r_ovld;
    logic [vpa_pkg::OUT_W-1:0] r_odata;

    logic                  ram_we;
    logic [XW-1:0]         ram_waddr, ram_raddr;
    vpa_pkg::t_seg         ram_wdata, ram_rdata;
    logic [CW-1:0]         raddr_w;

    logic          scan_end, exact, nh, ph, can_out, busy_idle;
    logic [AW-1:0] init_len, lenm;
    vpa_pkg::t_seg init_ent, merge_ent;
    logic [CW-1:0] merge_at;

    vpa_seg_ram #(
        .DATA_W(vpa_pkg::SEG_W),
        .DEPTH (vpa_pkg::MAX_SEG),
        .AW    (XW)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign busy_idle = (r_state == S_IDLE) && !r_done;
    assign s_axis_tready = busy_idle && !r_init;
    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = r_odata;
    assign can_out = !r_ovld || m_axis_tready;

    assign init_len = (r_base < r_tot) ? (r_tot - r_base) : '0;
    assign init_ent = '{start: r_base, length: init_len, owner: '0, hole: 1'b1};
    assign scan_end = (r_idx >= r_cnt) && !r_rvld;
    assign exact    = (r_pick_ent.length == r_size);
    assign nh       = r_next_vld && r_next_ent.hole;
    assign ph       = r_prev_vld && r_prev_ent.hole;
    assign lenm     = r_pick_ent.length + (nh ? r_next_ent.length : '0);

    always_comb begin
        if (ph) begin
            merge_ent = '{start: r_prev_ent.start, length: r_prev_ent.length + lenm,
                          owner: '0, hole: 1'b1};
            merge_at  = r_pick - CW'(1);
        end else begin
            merge_ent = '{start: r_pick_ent.start, length: lenm, owner: '0, hole: 1'b1};
            merge_at  = r_pick;
        end
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = init_ent;
        raddr_w   = r_idx;
        case (r_state)
            S_IDLE: begin
                ram_we = r_init && !r_done;
            end
            S_SCAN: begin
                if (scan_end && r_pick_vld) begin
                    if (r_type == vpa_pkg::REQ_ALLOC) begin
                        ram_we    = exact;
                        ram_waddr = r_pick[XW-1:0];
                        ram_wdata = '{start: r_pick_ent.start, length: r_size,
                                      owner: r_pid, hole: 1'b0};
                    end else begin
                        ram_we    = 1'b1;
                        ram_waddr = merge_at[XW-1:0];
                        ram_wdata = merge_ent;
                    end
                end
            end
            S_SHR: begin
                raddr_w   = r_idx - CW'(1);
                ram_we    = r_rvld;
                ram_waddr = r_ridx[XW-1:0];
                ram_wdata = ram_rdata;
            end
            S_SPL1: begin
                ram_we    = 1'b1;
                ram_waddr = XW'(r_pick + CW'(1));
                ram_wdata = '{start: r_pick_ent.start + r_size,
                              length: r_pick_ent.length - r_size, owner: '0, hole: 1'b1};
            end
            S_SPL2: begin
                ram_we    = 1'b1;
                ram_waddr = r_pick[XW-1:0];
                ram_wdata = '{start: r_pick_ent.start, length: r_size,
                              owner: r_pid, hole: 1'b0};
            end
            S_SHL: begin
                raddr_w   = r_idx + CW'(r_shd);
                ram_we    = r_rvld;
                ram_waddr = r_ridx[XW-1:0];
                ram_wdata = ram_rdata;
            end
            default: begin
            end
        endcase
        ram_raddr = raddr_w[XW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_init  <= 1'b1;
            r_tot   <= 16'd1024;
            r_base  <= 16'd256;
            r_ovld  <= 1'b0;
            r_rvld  <= 1'b0;
            r_cnt   <= '0;
            r_holes <= '0;
            r_owned <= '0;
            r_free  <= '0;
            r_largest <= '0;
        end else begin
            if (r_ovld && m_axis_tready) begin
                r_ovld <= 1'b0;
            end
            if (i_cfg_we) begin
                if (i_cfg_idx) begin
                    r_base <= i_cfg_data;
                end else begin
                    r_tot <= i_cfg_data;
                end
                r_init <= 1'b1;
            end
            case (r_state)
                S_IDLE: begin
                    if (r_done) begin
                        if (can_out) begin
                            r_ovld  <= 1'b1;
                            r_odata <= {7'b0, r_largest, r_owned, r_holes, r_free,
                                        (r_status == vpa_pkg::ST_OK) ? r_addr : 16'd0,
                                        r_status};
                            r_done  <= 1'b0;
                        end
                    end else if (r_init) begin
                        if (!i_cfg_we) begin
                            r_init <= 1'b0;
                        end
                        r_cnt     <= (r_base < r_tot) ? CW'(1) : '0;
                        r_holes   <= (r_base < r_tot) ? CW'(1) : '0;
                        r_owned   <= '0;
                        r_free    <= init_len;
                        r_largest <= init_len;
                    end else if (s_axis_tvalid) begin
                        r_type  <= s_axis_tuser;
                        r_pid   <= s_axis_tdata[7:0];
                        r_size  <= s_axis_tdata[23:8];
                        r_pol   <= s_axis_tdata[25:24];
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_idx      <= '0;
                    r_rvld     <= 1'b0;
                    r_pick_vld <= 1'b0;
                    r_prev_vld <= 1'b0;
                    r_next_vld <= 1'b0;
                    r_status   <= vpa_pkg::ST_OK;
                    r_state    <= S_SCAN;
                    if (r_type == vpa_pkg::REQ_ALLOC) begin
                        if (r_size == '0) begin
                            r_status <= vpa_pkg::ST_BAD_SIZE;
                            r_state  <= S_IDLE;
                            r_done   <= 1'b1;
                        end else if (r_size > r_free) begin
                            r_status <= vpa_pkg::ST_SHORT;
                            r_state  <= S_IDLE;
                            r_done   <= 1'b1;
                        end else if (r_pol == vpa_pkg::POL_INVALID) begin
                            r_status <= vpa_pkg::ST_BAD_POL;
                            r_state  <= S_IDLE;
                            r_done   <= 1'b1;
                        end
                    end
                end
                S_SCAN: begin
                    if (r_idx < r_cnt) begin
                        r_idx  <= r_idx + CW'(1);
                        r_ridx <= r_idx;
                        r_rvld <= 1'b1;
                    end else begin
                        r_rvld <= 1'b0;
                    end
                    if (r_rvld) begin
                        r_last_ent <= ram_rdata;
                        if (r_type == vpa_pkg::REQ_ALLOC) begin
                            if (ram_rdata.hole && ram_rdata.length >= r_size &&
                                (!r_pick_vld ||
                                 (r_pol == vpa_pkg::POL_BEST && ram_rdata.length < r_best) ||
                                 (r_pol == vpa_pkg::POL_WORST && ram_rdata.length > r_best))) begin
                                r_pick_vld <= 1'b1;
                                r_pick     <= r_ridx;
                                r_pick_ent <= ram_rdata;
                                r_best     <= ram_rdata.length;
                            end
                        end else begin
                            if (!r_pick_vld && !ram_rdata.hole && ram_rdata.owner == r_pid) begin
                                r_pick_vld <= 1'b1;
                                r_pick     <= r_ridx;
                                r_pick_ent <= ram_rdata;
                                r_prev_ent <= r_last_ent;
                                r_prev_vld <= (r_ridx != '0);
                            end
                            if (r_pick_vld && r_ridx == r_pick + CW'(1)) begin
                                r_next_ent <= ram_rdata;
                                r_next_vld <= 1'b1;
                            end
                        end
                    end
                    if (scan_end) begin
                        r_idx <= '0;
                        if (!r_pick_vld) begin
                            r_status <= (r_type == vpa_pkg::REQ_ALLOC) ?
                                        vpa_pkg::ST_NO_FIT : vpa_pkg::ST_ID_MISS;
                            r_state  <= S_IDLE;
                            r_done   <= 1'b1;
                        end else if (r_type == vpa_pkg::REQ_ALLOC) begin
                            r_addr <= r_pick_ent.start;
                            if (exact) begin
                                r_holes <= (r_holes != '0) ? r_holes - CW'(1) : r_holes;
                                r_owned <= r_owned + CW'(1);
                                r_free  <= r_free - r_size;
                                r_state <= S_LSCAN;
                            end else if (r_cnt >= CW'(vpa_pkg::MAX_SEG)) begin
                                r_status <= vpa_pkg::ST_FULL;
                                r_state  <= S_IDLE;
                                r_done   <= 1'b1;
                            end else begin
                                r_idx   <= r_cnt;
                                r_state <= S_SHR;
                            end
                        end else begin
                            r_addr  <= r_pick_ent.start;
                            r_owned <= r_owned - CW'(1);
                            r_holes <= r_holes + CW'(1) - CW'(nh) - CW'(ph);
                            r_free  <= r_free + r_pick_ent.length;
                            r_cnt   <= r_cnt - CW'(nh) - CW'(ph);
                            r_shd   <= 2'(nh) + 2'(ph);
                            r_end   <= r_cnt - CW'(nh) - CW'(ph);
                            r_idx   <= ph ? r_pick : r_pick + CW'(1);
                            r_state <= (nh || ph) ? S_SHL : S_LSCAN;
                            if (!(nh || ph)) begin
                                r_idx <= '0;
                            end
                        end
                    end
                end
                S_SHR: begin
                    if (r_idx > r_pick + CW'(1)) begin
                        r_idx  <= r_idx - CW'(1);
                        r_ridx <= r_idx;
                        r_rvld <= 1'b1;
                    end else begin
                        r_rvld <= 1'b0;
                        if (!r_rvld) begin
                            r_state <= S_SPL1;
                        end
                    end
                end
                S_SPL1: begin
                    r_state <= S_SPL2;
                end
                S_SPL2: begin
                    r_cnt   <= r_cnt + CW'(1);
                    r_owned <= r_owned + CW'(1);
                    r_free  <= r_free - r_size;
                    r_idx   <= '0;
                    r_state <= S_LSCAN;
                end
                S_SHL: begin
                    if (r_idx < r_end) begin
                        r_idx  <= r_idx + CW'(1);
                        r_ridx <= r_idx;
                        r_rvld <= 1'b1;
                    end else begin
                        r_rvld <= 1'b0;
                        if (!r_rvld) begin
                            r_idx   <= '0;
                            r_state <= S_LSCAN;
                        end
                    end
                end
                S_LSCAN: begin
                    if (r_idx == '0 && !r_rvld) begin
                        r_best <= '0;
                    end
                    if (r_idx < r_cnt) begin
                        r_idx  <= r_idx + CW'(1);
                        r_rvld <= 1'b1;
                    end else begin
                        r_rvld <= 1'b0;
                    end
                    if (r_rvld && ram_rdata.hole && ram_rdata.length > r_best) begin
                        r_best <= ram_rdata.length;
                    end
                    if (scan_end && !(r_idx == '0 && r_cnt != '0)) begin
                        r_largest <= r_best;
                        r_state   <= S_IDLE;
                        r_done    <= 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== sim/tb_variable_partition_allocator.sv =====
// Testbench for variable_partition_allocator: directed table, table full and extremes, then random requests,
// each result checked against an in-bench segment table allocator predictor.
// Depends on vpa_pkg and the allocator RTL.
module tb_variable_partition_allocator;

    localparam int CYCLE_LIMIT = 1500000;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_cfg_we;
    logic                          i_cfg_idx;
    logic [vpa_pkg::ADDR_W-1:0]    i_cfg_data;
    logic                          s_axis_tvalid;
    logic                          s_axis_tready;
    logic [vpa_pkg::IN_W-1:0]      s_axis_tdata;
    logic                          s_axis_tuser;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready;
    logic [vpa_pkg::OUT_W-1:0]     m_axis_tdata;

    typedef struct packed {
        logic [15:0] largest;
        logic [6:0]  owned;
        logic [6:0]  holes;
        logic [15:0] free_units;
        logic [15:0] addr;
        logic [2:0]  status;
    } t_alloc_result;

    typedef struct {
        logic        kind;
        logic [7:0]  pid;
        logic [15:0] size;
        logic [1:0]  pol;
        logic        has_status;
        logic [2:0]  status;
    } t_row;

    variable_partition_allocator i_dut (.*);

    // predictor state
    logic [15:0] mem_total, mem_base;
    logic [15:0] seg_st[vpa_pkg::MAX_SEG];
    logic [15:0] seg_len[vpa_pkg::MAX_SEG];
    logic [7:0]  seg_own[vpa_pkg::MAX_SEG];
    logic        seg_free[vpa_pkg::MAX_SEG];
    int          nseg, nfree_units, nholes, nowned;

    t_alloc_result pending_results[$];
    int  errors = 0;
    int  cycles = 0;
    int  sent = 0;
    int  received = 0;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    logic [7:0] live_ids[$];

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_variable_partition_allocator failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch result %0d %s: got %0d want %0d", received, what, got, want);
        errors++;
    endtask

    function automatic void table_reinit();
        for (int k = 0; k < vpa_pkg::MAX_SEG; k++) begin
            seg_st[k] = '0; seg_len[k] = '0; seg_own[k] = '0; seg_free[k] = 1'b0;
        end
        nowned = 0;
        if (mem_base < mem_total) begin
            seg_st[0] = mem_base; seg_len[0] = mem_total - mem_base; seg_free[0] = 1'b1;
            nseg = 1; nfree_units = int'(seg_len[0]); nholes = 1;
        end else begin
            nseg = 0; nfree_units = 0; nholes = 0;
        end
    endfunction

    function automatic void drop_seg(int k);
        for (int j = k; j + 1 < nseg; j++) begin
            seg_st[j] = seg_st[j+1]; seg_len[j] = seg_len[j+1];
            seg_own[j] = seg_own[j+1]; seg_free[j] = seg_free[j+1];
        end
        if (nseg > 0) nseg--;
    endfunction

    function automatic t_alloc_result predict_alloc(logic kind, logic [7:0] pid,
                                                    logic [15:0] size, logic [1:0] pol);
        t_alloc_result r;
        int pick, best, i;
        logic [2:0] st;
        logic [15:0] addr;
        pick = -1; best = 0; addr = '0; st = vpa_pkg::ST_OK;
        if (kind == vpa_pkg::REQ_ALLOC) begin
            if (size == 0) st = vpa_pkg::ST_BAD_SIZE;
            else if (size > nfree_units) st = vpa_pkg::ST_SHORT;
            else if (pol == vpa_pkg::POL_INVALID) st = vpa_pkg::ST_BAD_POL;
            else begin
                for (i = 0; i < nseg; i++) begin
                    if (!seg_free[i] || seg_len[i] < size) continue;
                    if (pol == vpa_pkg::POL_FIRST) begin pick = i; break; end
                    if (pick < 0 || (pol == vpa_pkg::POL_BEST && seg_len[i] < best) ||
                        (pol == vpa_pkg::POL_WORST && seg_len[i] > best)) begin
                        pick = i; best = int'(seg_len[i]);
                    end
                end
                if (pick < 0) st = vpa_pkg::ST_NO_FIT;
                else if (seg_len[pick] != size && nseg >= vpa_pkg::MAX_SEG) st = vpa_pkg::ST_FULL;
                else begin
                    if (seg_len[pick] == size) nholes--;
                    else begin
                        for (int j = nseg; j > pick + 1; j--) begin
                            seg_st[j] = seg_st[j-1]; seg_len[j] = seg_len[j-1];
                            seg_own[j] = seg_own[j-1]; seg_free[j] = seg_free[j-1];
                        end
                        seg_st[pick+1] = seg_st[pick] + size;
                        seg_len[pick+1] = seg_len[pick] - size;
                        seg_own[pick+1] = '0; seg_free[pick+1] = 1'b1;
                        seg_len[pick] = size;
                        nseg++;
                    end
                    seg_free[pick] = 1'b0; seg_own[pick] = pid;
                    nowned++;
                    nfree_units = (nfree_units - int'(size)) & 16'hFFFF;
                    addr = seg_st[pick];
                end
            end
        end else begin
            for (i = 0; i < nseg; i++)
                if (!seg_free[i] && seg_own[i] == pid) break;
            if (i >= nseg) st = vpa_pkg::ST_ID_MISS;
            else begin
                addr = seg_st[i];
                seg_free[i] = 1'b1; seg_own[i] = '0;
                nowned--; nholes++;
                nfree_units = (nfree_units + int'(seg_len[i])) & 16'hFFFF;
                if (i + 1 < nseg && seg_free[i+1]) begin
                    seg_len[i] = seg_len[i] + seg_len[i+1];
                    drop_seg(i + 1); nholes--;
                end
                if (i > 0 && seg_free[i-1]) begin
                    seg_len[i-1] = seg_len[i-1] + seg_len[i];
                    drop_seg(i); nholes--;
                end
            end
        end
        r.status = st;
        r.addr = (st == vpa_pkg::ST_OK) ? addr : 16'd0;
        r.free_units = 16'(nfree_units);
        r.holes = 7'(nholes);
        r.owned = 7'(nowned);
        r.largest = '0;
        for (i = 0; i < nseg; i++)
            if (seg_free[i] && seg_len[i] > r.largest) r.largest = seg_len[i];
        return r;
    endfunction

    // result monitor and stall generator
    always @(posedge i_clk) begin
        t_alloc_result got, want;
        if (m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[$bits(t_alloc_result)-1:0];
            if (pending_results.size() == 0) begin
                $display("unexpected result %0d", received);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status)
                    report_mismatch("status", int'(got.status), int'(want.status));
                if (got.addr !== want.addr)
                    report_mismatch("start_address", int'(got.addr), int'(want.addr));
                if (got.free_units !== want.free_units)
                    report_mismatch("free_units", int'(got.free_units), int'(want.free_units));
                if (got.holes !== want.holes)
                    report_mismatch("hole_total", int'(got.holes), int'(want.holes));
                if (got.owned !== want.owned)
                    report_mismatch("owned_total", int'(got.owned), int'(want.owned));
                if (got.largest !== want.largest)
                    report_mismatch("largest_hole", int'(got.largest), int'(want.largest));
            end
            received <= received + 1;
        end
    end

    always @(negedge i_clk)
        m_axis_tready <= !i_rst_n ? 1'b0 : ($urandom_range(99) >= recv_stall_pct);

    task automatic send_request(logic kind, logic [7:0] pid, logic [15:0] size, logic [1:0] pol);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tdata  <= {6'd0, pol, size, pid};
        s_axis_tuser  <= kind;
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pending_results.push_back(predict_alloc(kind, pid, size, pol));
        sent++;
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (4 * vpa_pkg::MAX_SEG + 20) @(negedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [15:0] value);
        drain_results();
        i_cfg_we <= 1'b1; i_cfg_idx <= idx; i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == 1'b0) mem_total = value; else mem_base = value;
        table_reinit();
        live_ids.delete();
        repeat (4) @(negedge i_clk);
    endtask

    task automatic random_phase(int count, int max_size);
        logic [7:0] pid;
        logic [15:0] size;
        int pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 55) begin
                pid = 8'($urandom);
                size = (pick < 3) ? 16'($urandom) : 16'($urandom_range(max_size, 1));
                send_request(vpa_pkg::REQ_ALLOC, pid, size, 2'($urandom_range(2)));
                live_ids.push_back(pid);
            end else if (pick < 88 && live_ids.size() > 0) begin
                pid = live_ids[$urandom_range(live_ids.size() - 1)];
                send_request(vpa_pkg::REQ_FREE, pid, 16'($urandom), 2'($urandom));
            end else begin
                send_request(1'($urandom), 8'($urandom),
                             ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom), 2'($urandom));
            end
        end
    endtask

    t_row directed_rows[] = '{
        '{vpa_pkg::REQ_FREE,  8'd5,   16'd10,   vpa_pkg::POL_FIRST,   1, vpa_pkg::ST_ID_MISS},
        '{vpa_pkg::REQ_ALLOC, 8'd1,   16'd0,    vpa_pkg::POL_FIRST,   1, vpa_pkg::ST_BAD_SIZE},
        '{vpa_pkg::REQ_ALLOC, 8'd1,   16'hFFFF, vpa_pkg::POL_BEST,    1, vpa_pkg::ST_SHORT},
        '{vpa_pkg::REQ_ALLOC, 8'd1,   16'd10,   vpa_pkg::POL_INVALID, 1, vpa_pkg::ST_BAD_POL},
        '{vpa_pkg::REQ_ALLOC, 8'd1,   16'd100,  vpa_pkg::POL_FIRST,   0, vpa_pkg::ST_OK},
        '{vpa_pkg::REQ_ALLOC, 8'd2,   16'd50,   vpa_pkg::POL_FIRST,   0, vpa_pkg::ST_OK},
        '{vpa_pkg::REQ_ALLOC, 8'd255, 16'd200,  vpa_pkg::POL_BEST,    0, vpa_pkg::ST_OK},
        '{vpa_pkg::REQ_ALLOC, 8'd0,   16'd30,   vpa_pkg::POL_WORST,   0, vpa_pkg::ST_OK},
        '{vpa_pkg::REQ_FREE,  8'd1,   16'd0,    vpa_pkg::POL_FIRST,   0, vpa_pkg::ST_OK},
        '{vpa_pkg::REQ_FREE,  8'd255, 16'hFFFF, vpa_pkg::POL_INVALID, 0, vpa_pkg::ST_OK},
        '{vpa_pkg::REQ_ALLOC, 8'd3,   16'd40,   vpa_pkg::POL_BEST,    0, vpa_pkg::ST_OK},
        '{vpa_pkg::REQ_ALLOC, 8'd4,   16'd40,   vpa_pkg::POL_WORST,   0, vpa_pkg::ST_OK},
        '{vpa_pkg::REQ_ALLOC, 8'd6,   16'd500,  vpa_pkg::POL_FIRST,   0, vpa_pkg::ST_OK},
        '{vpa_pkg::REQ_FREE,  8'd2,   16'd0,    vpa_pkg::POL_FIRST,   0, vpa_pkg::ST_OK},
        '{vpa_pkg::REQ_FREE,  8'd3,   16'd0,    vpa_pkg::POL_FIRST,   0, vpa_pkg::ST_OK},
        '{vpa_pkg::REQ_FREE,  8'd0,   16'd0,    vpa_pkg::POL_FIRST,   0, vpa_pkg::ST_OK},
        '{vpa_pkg::REQ_FREE,  8'd0,   16'd0,    vpa_pkg::POL_FIRST,   1, vpa_pkg::ST_ID_MISS},
        '{vpa_pkg::REQ_ALLOC, 8'd7,   16'd768,  vpa_pkg::POL_FIRST,   0, vpa_pkg::ST_OK}
    };

    initial begin
        t_alloc_result want;
        i_rst_n = 1'b0; i_cfg_we = 1'b0; i_cfg_idx = 1'b0; i_cfg_data = '0;
        s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tuser = 1'b0; m_axis_tready = 1'b0;
        mem_total = 16'd1024; mem_base = 16'd256;
        table_reinit();
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (4) @(negedge i_clk);

        foreach (directed_rows[k]) begin
            send_request(directed_rows[k].kind, directed_rows[k].pid, directed_rows[k].size,
                         directed_rows[k].pol);
            want = pending_results[$];
            if (directed_rows[k].has_status && want.status !== directed_rows[k].status)
                report_mismatch("table status", int'(want.status),
                                int'(directed_rows[k].status));
        end

        // table full: small slices of a large pool
        write_reg(1'b0, 16'd200);
        write_reg(1'b1, 16'd0);
        for (int n = 0; n < 66; n++)
            send_request(vpa_pkg::REQ_ALLOC, n[7:0], 16'd1, vpa_pkg::POL_FIRST);

        // empty memory, then extremes
        write_reg(1'b1, 16'hFFFE);
        send_request(vpa_pkg::REQ_ALLOC, 8'd1, 16'd1, vpa_pkg::POL_FIRST);
        send_request(vpa_pkg::REQ_FREE, 8'd1, 16'd0, vpa_pkg::POL_FIRST);
        write_reg(1'b0, 16'hFFFF);
        send_request(vpa_pkg::REQ_ALLOC, 8'd9, 16'd1, vpa_pkg::POL_WORST);
        send_request(vpa_pkg::REQ_ALLOC, 8'd9, 16'd1, vpa_pkg::POL_WORST);

        write_reg(1'b0, 16'd1024); write_reg(1'b1, 16'd256);
        random_phase(240, 40);
        drain_results();
        send_idle_pct = 88;
        random_phase(170, 60);
        send_idle_pct = 0; recv_stall_pct = 88;
        write_reg(1'b0, 16'd2);
        write_reg(1'b1, 16'd0);
        random_phase(60, 2);
        write_reg(1'b0, 16'hFFFF);
        random_phase(200, 4000);
        send_idle_pct = 12; recv_stall_pct = 12;
        write_reg(1'b0, 16'd300); write_reg(1'b1, 16'd10);
        random_phase(300, 12);

        drain_results();
        $display("sent %0d requests over table full, empty memory and several size settings,",
                 sent);
        $display("with idle and stall phases; %0d results checked", received);
        if (errors == 0 && pending_results.size() == 0)
            $display("tb_variable_partition_allocator passed");
        else
            $display("tb_variable_partition_allocator failed");
        $finish;
    end
endmodule
